### hdl/ipds_pkg.sv
// ----------------------------------------------------------------------------
// IMTS pulse dial sequencer package
// Shared codes, the control word layout and the microcode store for the
// signalling sequencer, plus the constants of the duration arithmetic.
// ----------------------------------------------------------------------------
package ipds_pkg;

   localparam int RATE_W = 18;
   localparam int MS_W   = 11;
   localparam int PROD_W = 29;
   localparam int LEN_W  = 19;
   localparam int PC_W   = 5;
   localparam int CNT_W  = 4;

   // floor(x / 1000) is taken as floor((x >> 3) / 125). The shifted value has
   // 26 bits, and a 27-bit reciprocal with a shift of 33 gives the exact
   // quotient for every such value.
   localparam int DIV_SHIFT = 3;
   localparam int QX_W      = PROD_W - DIV_SHIFT;
   localparam int RECIP_W   = 27;
   localparam int RECIP_SH  = 33;
   localparam logic [RECIP_W-1:0] RECIP_125 = 27'd68719477;

   localparam logic [3:0]       MAX_DIGIT  = 4'd9;
   localparam logic [CNT_W-1:0] TEN_PULSES = 4'd10;
   localparam logic [CNT_W-1:0] DISC_PAIRS = 4'd15;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_DIGIT = 2'd1,
      OP_END   = 2'd2,
      OP_DISC  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      TONE_SIL    = 3'd0,
      TONE_IDLE   = 3'd1,
      TONE_CONN   = 3'd2,
      TONE_DISC   = 3'd3,
      TONE_FINISH = 3'd4
   } tone_type;

   typedef enum logic [2:0] {
      MARK_NONE    = 3'd0,
      MARK_SEIZE   = 3'd1,
      MARK_DASH    = 3'd2,
      MARK_DIGIT   = 3'd3,
      MARK_NEWLINE = 3'd4
   } marker_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ORDER    = 2'd1,
      ST_TOO_MANY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_STATION = 2'd1,
      PH_DIAL    = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      TS_SIL   = 3'd0,
      TS_GUARD = 3'd1,
      TS_CONN  = 3'd2,
      TS_DISC  = 3'd3,
      TS_DONE  = 3'd4,
      TS_SPACE = 3'd5
   } tone_sel_type;

   typedef enum logic [2:0] {
      MS_NONE        = 3'd0,
      MS_SEIZE       = 3'd1,
      MS_DASH        = 3'd2,
      MS_NEWLINE     = 3'd3,
      MS_FIRST_DIGIT = 3'd4
   } mark_sel_type;

   typedef enum logic [3:0] {
      D_0    = 4'd0,
      D_25   = 4'd1,
      D_40   = 4'd2,
      D_50   = 4'd3,
      D_60   = 4'd4,
      D_190  = 4'd5,
      D_350  = 4'd6,
      D_400  = 4'd7,
      D_600  = 4'd8,
      D_1000 = 4'd9,
      D_2000 = 4'd10
   } dur_type;

   typedef enum logic [1:0] {
      FL_NEXT            = 2'd0,
      FL_LOOP            = 2'd1,
      FL_END             = 2'd2,
      FL_END_UNLESS_FULL = 2'd3
   } flow_type;

   typedef enum logic [2:0] {
      UPD_NONE        = 3'd0,
      UPD_CALL_START  = 3'd1,
      UPD_STATION_INC = 3'd2,
      UPD_TO_DIAL     = 3'd3,
      UPD_DIAL_INC    = 3'd4,
      UPD_CALL_CLEAR  = 3'd5
   } upd_type;

   typedef struct packed {
      tone_sel_type    tone_sel;
      dur_type         dur_sel;
      mark_sel_type    mark_sel;
      flow_type        flow;
      upd_type         upd;
      logic [PC_W-1:0] target;
   } ucode_type;

   // One signalling segment on its way to the duration pipeline.
   typedef struct packed {
      tone_type   tone;
      dur_type    dur_sel;
      marker_type marker;
      logic [3:0] mdig;
      status_type status;
      logic       fin;
   } seg_type;

   // Program entry points.
   localparam logic [PC_W-1:0] UA_START   = 5'd0;
   localparam logic [PC_W-1:0] UA_STATION = 5'd4;
   localparam logic [PC_W-1:0] UA_DIAL    = 5'd8;
   localparam logic [PC_W-1:0] UA_END     = 5'd11;
   localparam logic [PC_W-1:0] UA_DISC    = 5'd13;
   localparam logic [PC_W-1:0] UA_DISC_LP = 5'd14;
   localparam logic [PC_W-1:0] UA_ERROR   = 5'd18;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_type w;
      w = '{TS_SIL, D_0, MS_NONE, FL_END, UPD_NONE, UA_ERROR};
      unique case (addr)
         // Call start: pause, off-hook guard, seize, guard.
         5'd0:  w = '{TS_SIL,   D_600,  MS_NONE,  FL_NEXT, UPD_NONE, UA_START};
         5'd1:  w = '{TS_GUARD, D_350,  MS_NONE,  FL_NEXT, UPD_NONE, UA_START};
         5'd2:  w = '{TS_CONN,  D_50,   MS_SEIZE, FL_NEXT, UPD_NONE, UA_START};
         5'd3:  w = '{TS_GUARD, D_1000, MS_DASH,  FL_END,  UPD_CALL_START, UA_START};
         // Station digit: 25/25 ms pulses, gap, separator after the last one.
         5'd4:  w = '{TS_CONN,  D_25,  MS_FIRST_DIGIT, FL_NEXT, UPD_NONE, UA_STATION};
         5'd5:  w = '{TS_SPACE, D_25,  MS_NONE, FL_LOOP, UPD_NONE, UA_STATION};
         5'd6:  w = '{TS_SPACE, D_190, MS_NONE, FL_END_UNLESS_FULL, UPD_STATION_INC,
                      UA_STATION};
         5'd7:  w = '{TS_SIL,   D_2000, MS_DASH, FL_END, UPD_TO_DIAL, UA_STATION};
         // Dialed digit: 60/40 ms pulses and a guard gap.
         5'd8:  w = '{TS_CONN,  D_60,  MS_FIRST_DIGIT, FL_NEXT, UPD_NONE, UA_DIAL};
         5'd9:  w = '{TS_GUARD, D_40,  MS_NONE, FL_LOOP, UPD_NONE, UA_DIAL};
         5'd10: w = '{TS_GUARD, D_400, MS_NONE, FL_END,  UPD_DIAL_INC, UA_DIAL};
         // Call end.
         5'd11: w = '{TS_SIL,   D_600, MS_NEWLINE, FL_NEXT, UPD_NONE, UA_END};
         5'd12: w = '{TS_DONE,  D_0,   MS_NONE, FL_END, UPD_CALL_CLEAR, UA_END};
         // Disconnect: pause, disconnect/guard pairs, pause, done.
         5'd13: w = '{TS_SIL,   D_600, MS_NONE, FL_NEXT, UPD_NONE, UA_DISC};
         5'd14: w = '{TS_DISC,  D_25,  MS_NONE, FL_NEXT, UPD_NONE, UA_DISC_LP};
         5'd15: w = '{TS_GUARD, D_25,  MS_NONE, FL_LOOP, UPD_NONE, UA_DISC_LP};
         5'd16: w = '{TS_SIL,   D_600, MS_NONE, FL_NEXT, UPD_NONE, UA_DISC};
         5'd17: w = '{TS_DONE,  D_0,   MS_NONE, FL_END,  UPD_NONE, UA_DISC};
         default: w = '{TS_SIL, D_0, MS_NONE, FL_END, UPD_NONE, UA_ERROR};
      endcase
      return w;
   endfunction

   function automatic logic [MS_W-1:0] dur_ms(input dur_type sel);
      logic [MS_W-1:0] ms;
      ms = '0;
      unique case (sel)
         D_0:     ms = 11'd0;
         D_25:    ms = 11'd25;
         D_40:    ms = 11'd40;
         D_50:    ms = 11'd50;
         D_60:    ms = 11'd60;
         D_190:   ms = 11'd190;
         D_350:   ms = 11'd350;
         D_400:   ms = 11'd400;
         D_600:   ms = 11'd600;
         D_1000:  ms = 11'd1000;
         D_2000:  ms = 11'd2000;
         default: ms = 11'd0;
      endcase
      return ms;
   endfunction

endpackage

### hdl/ipds_sequencer.sv
// ----------------------------------------------------------------------------
// IMTS pulse dial microcode sequencer
// Checks each request against the call state, picks a program entry and
// steps through the control store, issuing one segment per step.
// ----------------------------------------------------------------------------
module ipds_sequencer
   import ipds_pkg::*;
#(
   parameter int STATION_DIGITS  = 7,
   parameter int MAX_DIAL_DIGITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [3:0] req_digit,
   input  logic       adv,
   output logic       seg_valid,
   output seg_type    seg
);

   localparam int SW = $clog2(STATION_DIGITS + 1);
   localparam int DW = $clog2(MAX_DIAL_DIGITS + 1);

   logic                busy_ff, busy_in;
   logic [PC_W-1:0]     pc_ff, pc_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    lim_ff, lim_in;
   logic [3:0]          digit_ff, digit_in;
   status_type          status_ff, status_in;
   phase_type           phase_ff, phase_in;
   logic [SW-1:0]       station_ff, station_in;
   logic [DW-1:0]       dialed_ff, dialed_in;

   ucode_type           uw;
   logic                accept;
   logic                issue;
   logic                station_full;
   logic [PC_W-1:0]     entry_pc;
   status_type          entry_status;
   logic [CNT_W-1:0]    pulses;

   assign accept    = req_valid && !busy_ff;
   assign issue     = busy_ff && adv;
   assign req_ready = !busy_ff;
   assign seg_valid = busy_ff;
   assign uw        = ucode_rom(pc_ff);
   assign pulses    = (req_digit == 4'd0) ? TEN_PULSES : req_digit;

   assign station_full = ((SW+1)'(station_ff) + (SW+1)'(1)) >= (SW+1)'(STATION_DIGITS);

   // Request check and program entry.
   always_comb begin
      entry_pc     = UA_ERROR;
      entry_status = ST_ORDER;
      unique case (opcode_type'(req_opcode))
         OP_START: begin
            if (phase_ff == PH_IDLE) begin
               entry_pc     = UA_START;
               entry_status = ST_OK;
            end
         end
         OP_DIGIT: begin
            if (req_digit > MAX_DIGIT || phase_ff == PH_IDLE) begin
               entry_status = ST_ORDER;
            end else if (phase_ff == PH_STATION) begin
               entry_pc     = UA_STATION;
               entry_status = ST_OK;
            end else if (dialed_ff >= DW'(MAX_DIAL_DIGITS)) begin
               entry_status = ST_TOO_MANY;
            end else begin
               entry_pc     = UA_DIAL;
               entry_status = ST_OK;
            end
         end
         OP_END: begin
            if (phase_ff == PH_DIAL) begin
               entry_pc     = UA_END;
               entry_status = ST_OK;
            end
         end
         OP_DISC: begin
            if (phase_ff == PH_IDLE) begin
               entry_pc     = UA_DISC;
               entry_status = ST_OK;
            end
         end
         default: begin
            entry_pc     = UA_ERROR;
            entry_status = ST_ORDER;
         end
      endcase
   end

   // Segment fields from the current control word.
   always_comb begin
      seg.dur_sel = uw.dur_sel;
      seg.status  = status_ff;
      seg.mdig    = 4'd0;
      unique case (uw.tone_sel)
         TS_SIL:   seg.tone = TONE_SIL;
         TS_GUARD: seg.tone = TONE_IDLE;
         TS_CONN:  seg.tone = TONE_CONN;
         TS_DISC:  seg.tone = TONE_DISC;
         TS_DONE:  seg.tone = TONE_FINISH;
         // Spaces after odd pulses are silent, after even pulses guard tone.
         TS_SPACE: seg.tone = cnt_ff[0] ? TONE_SIL : TONE_IDLE;
         default:  seg.tone = TONE_SIL;
      endcase
      unique case (uw.mark_sel)
         MS_NONE:    seg.marker = MARK_NONE;
         MS_SEIZE:   seg.marker = MARK_SEIZE;
         MS_DASH:    seg.marker = MARK_DASH;
         MS_NEWLINE: seg.marker = MARK_NEWLINE;
         MS_FIRST_DIGIT: begin
            if (cnt_ff == CNT_W'(1)) begin
               seg.marker = MARK_DIGIT;
               seg.mdig   = digit_ff;
            end else begin
               seg.marker = MARK_NONE;
            end
         end
         default: seg.marker = MARK_NONE;
      endcase
      seg.fin = (uw.flow == FL_END) || (uw.flow == FL_END_UNLESS_FULL && !station_full);
   end

   // Step counter, jumps and call state updates.
   always_comb begin
      busy_in    = busy_ff;
      pc_in      = pc_ff;
      cnt_in     = cnt_ff;
      lim_in     = lim_ff;
      digit_in   = digit_ff;
      status_in  = status_ff;
      phase_in   = phase_ff;
      station_in = station_ff;
      dialed_in  = dialed_ff;
      if (accept) begin
         busy_in   = 1'b1;
         pc_in     = entry_pc;
         cnt_in    = CNT_W'(1);
         lim_in    = (opcode_type'(req_opcode) == OP_DISC) ? DISC_PAIRS : pulses;
         digit_in  = req_digit;
         status_in = entry_status;
      end else if (issue) begin
         unique case (uw.flow)
            FL_NEXT: pc_in = pc_ff + PC_W'(1);
            FL_LOOP: begin
               if (cnt_ff != lim_ff) begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  pc_in  = uw.target;
               end else begin
                  pc_in = pc_ff + PC_W'(1);
               end
            end
            FL_END: busy_in = 1'b0;
            FL_END_UNLESS_FULL: begin
               if (station_full) begin
                  pc_in = pc_ff + PC_W'(1);
               end else begin
                  busy_in = 1'b0;
               end
            end
            default: busy_in = 1'b0;
         endcase
         unique case (uw.upd)
            UPD_NONE: ;
            UPD_CALL_START: begin
               phase_in   = PH_STATION;
               station_in = '0;
               dialed_in  = '0;
            end
            UPD_STATION_INC: station_in = station_ff + SW'(1);
            UPD_TO_DIAL:     phase_in   = PH_DIAL;
            UPD_DIAL_INC:    dialed_in  = dialed_ff + DW'(1);
            UPD_CALL_CLEAR: begin
               phase_in   = PH_IDLE;
               station_in = '0;
               dialed_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         pc_ff      <= UA_ERROR;
         cnt_ff     <= '0;
         lim_ff     <= '0;
         status_ff  <= ST_OK;
         phase_ff   <= PH_IDLE;
         station_ff <= '0;
         dialed_ff  <= '0;
      end else begin
         busy_ff    <= busy_in;
         pc_ff      <= pc_in;
         cnt_ff     <= cnt_in;
         lim_ff     <= lim_in;
         status_ff  <= status_in;
         phase_ff   <= phase_in;
         station_ff <= station_in;
         dialed_ff  <= dialed_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

### hdl/ipds_seg_pipe.sv
// ----------------------------------------------------------------------------
// IMTS pulse dial segment pipeline
// Turns a segment's duration code into samples, floor(ms * rate / 1000), in
// two multiply stages and holds the finished segment in the output register.
// ----------------------------------------------------------------------------
module ipds_seg_pipe
   import ipds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [RATE_W-1:0] rate,
   input  logic              seg_valid,
   input  seg_type           seg,
   output logic              adv,
   output logic              out_valid,
   input  logic              out_ready,
   output seg_type           out_seg,
   output logic [LEN_W-1:0]  out_len
);

   logic                         s1_valid_ff;
   seg_type                      s1_seg_ff;
   logic                         s2_valid_ff;
   seg_type                      s2_seg_ff;
   logic [PROD_W-1:0]            s2_prod_ff, s2_prod_in;
   logic                         out_valid_ff;
   seg_type                      out_seg_ff;
   logic [LEN_W-1:0]             out_len_ff, out_len_in;
   logic [QX_W-1:0]              qx;
   logic [QX_W+RECIP_W-1:0]      qprod;

   // The whole pipeline moves together whenever the output register frees up.
   assign adv = !out_valid_ff || out_ready;

   assign s2_prod_in = PROD_W'(dur_ms(s1_seg_ff.dur_sel)) * PROD_W'(rate);
   assign qx         = s2_prod_ff[PROD_W-1:DIV_SHIFT];
   assign qprod      = (QX_W+RECIP_W)'(qx) * (QX_W+RECIP_W)'(RECIP_125);
   assign out_len_in = qprod[RECIP_SH +: LEN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= seg_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_seg_ff  <= seg;
         s2_seg_ff  <= s1_seg_ff;
         s2_prod_ff <= s2_prod_in;
         out_seg_ff <= s2_seg_ff;
         out_len_ff <= out_len_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_seg   = out_seg_ff;
   assign out_len   = out_len_ff;

endmodule

### hdl/imts_pulse_dial_sequencer.sv
// ----------------------------------------------------------------------------
// IMTS pulse dial sequencer
// Turns call-control requests and digits into IMTS signalling tone segments.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_ (opcode and digit); each one yields a run of tone
// segments on rsp_, with rsp_tlast on the final segment of the run. A request
// out of order or beyond the dialed digit limit yields a single segment with
// an error status and zero length, and leaves the call state as it was.
// csr_we writes the sample rate used to scale every segment duration; write
// it only while no run is in flight.
// Once a request is taken, the microcode sequencer issues one segment per
// cycle from its control store while the pipeline advances, so a request
// with n segments (one to 33) holds req_tready low until the last is issued.
// Each segment passes the s1 and s2 registers to the output register,
// through two registered multiplies. The next request is taken while the
// previous run drains. A full output register holds while rsp_tready is low,
// and the sequencer and the duration pipeline stall with it; nothing is dropped.
// Reset returns the call to idle, clears the digit counts and sets the
// sample rate to 48000.
// ----------------------------------------------------------------------------
module imts_pulse_dial_sequencer
   import ipds_pkg::*;
#(
   parameter int STATION_DIGITS  = 7,
   parameter int MAX_DIAL_DIGITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // opcode[1:0], digit[5:2], zero pad
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // tone[2:0], length_samples[21:3],
                                          // marker[24:22], marker_digit[28:25],
                                          // status[30:29], zero pad
   output logic              rsp_tlast,
   input  logic              csr_we,
   input  logic [RATE_W-1:0] csr_wdata
);

   localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

   logic [RATE_W-1:0] rate_ff;
   logic              adv;
   logic              seg_valid;
   seg_type           seg;
   seg_type           out_seg;
   logic [LEN_W-1:0]  out_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_we) begin
         rate_ff <= csr_wdata;
      end
   end

   ipds_sequencer #(
      .STATION_DIGITS  (STATION_DIGITS),
      .MAX_DIAL_DIGITS (MAX_DIAL_DIGITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tdata[1:0]),
      .req_digit  (req_tdata[5:2]),
      .adv        (adv),
      .seg_valid  (seg_valid),
      .seg        (seg)
   );

   ipds_seg_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .rate      (rate_ff),
      .seg_valid (seg_valid),
      .seg       (seg),
      .adv       (adv),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_seg   (out_seg),
      .out_len   (out_len)
   );

   assign rsp_tdata = {1'b0, out_seg.status, out_seg.mdig, out_seg.marker,
                       out_len, out_seg.tone};
   assign rsp_tlast = out_seg.fin;

endmodule

### verif/imts_pulse_dial_sequencer_tb.sv
// ----------------------------------------------------------------------------
// IMTS pulse dial sequencer testbench
// Drives call-control requests into the sequencer and predicts every tone
// segment. Each segment that comes out is checked field by field against the
// prediction. Directed requests cover the error paths and the digit extremes.
// Random calls follow at several sample rates, with random idling on both
// sides and one long output stall.
// ----------------------------------------------------------------------------
module imts_pulse_dial_sequencer_tb
   import ipds_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STATION_LEN     = 7;
   localparam int DIAL_MAX        = 64;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 12;
   localparam int PHASE_REQUESTS  = 38;

   typedef struct {
      tone_type         tone;
      logic [LEN_W-1:0] length;
      marker_type       marker;
      logic [3:0]       mdig;
      status_type       status;
      logic             last;
   } segment_type;

   class segment_scoreboard;
      logic [RATE_W-1:0] rate;
      phase_type         phase;
      int unsigned       station_cnt;
      int unsigned       dialed_cnt;
      int                errors;
      segment_type       pending_segments[$];

      function new();
         rate        = 18'd48000;
         phase       = PH_IDLE;
         station_cnt = 0;
         dialed_cnt  = 0;
         errors      = 0;
      endfunction

      function logic [LEN_W-1:0] scaled_len(int unsigned ms);
         logic [63:0] prod;
         prod = 64'(ms) * 64'(rate);
         return LEN_W'(prod / 64'd1000);
      endfunction

      function void push_segment(tone_type tone, int unsigned ms, marker_type marker,
                                 logic [3:0] mdig, status_type status);
         segment_type seg;
         seg.tone   = tone;
         seg.length = scaled_len(ms);
         seg.marker = marker;
         seg.mdig   = mdig;
         seg.status = status;
         seg.last   = 1'b0;
         pending_segments.push_back(seg);
      endfunction

      function void push_error(status_type status);
         push_segment(TONE_SIL, 0, MARK_NONE, 4'd0, status);
      endfunction

      function void predict_request(opcode_type op, logic [3:0] d);
         int unsigned pulses;
         int unsigned p;
         tone_type    space;
         segment_type seg;
         pulses = (d == 4'd0) ? 10 : int'(d);
         space  = TONE_SIL;
         case (op)
            OP_START: begin
               if (phase != PH_IDLE) begin
                  push_error(ST_ORDER);
               end else begin
                  push_segment(TONE_SIL, 600, MARK_NONE, 4'd0, ST_OK);
                  push_segment(TONE_IDLE, 350, MARK_NONE, 4'd0, ST_OK);
                  push_segment(TONE_CONN, 50, MARK_SEIZE, 4'd0, ST_OK);
                  push_segment(TONE_IDLE, 1000, MARK_DASH, 4'd0, ST_OK);
                  phase       = PH_STATION;
                  station_cnt = 0;
                  dialed_cnt  = 0;
               end
            end
            OP_DIGIT: begin
               if (d > MAX_DIGIT || phase == PH_IDLE) begin
                  push_error(ST_ORDER);
               end else if (phase == PH_STATION) begin
                  // Station pulses alternate silent and guard spaces, and the
                  // gap after the digit keeps the tone of the last space.
                  for (p = 1; p <= pulses; p++) begin
                     space = (p % 2 == 1) ? TONE_SIL : TONE_IDLE;
                     push_segment(TONE_CONN, 25, (p == 1) ? MARK_DIGIT : MARK_NONE,
                                  (p == 1) ? d : 4'd0, ST_OK);
                     push_segment(space, 25, MARK_NONE, 4'd0, ST_OK);
                  end
                  push_segment(space, 190, MARK_NONE, 4'd0, ST_OK);
                  station_cnt = (station_cnt + 1) % 8;
                  if (station_cnt >= STATION_LEN) begin
                     push_segment(TONE_SIL, 2000, MARK_DASH, 4'd0, ST_OK);
                     phase = PH_DIAL;
                  end
               end else if (dialed_cnt >= DIAL_MAX) begin
                  push_error(ST_TOO_MANY);
               end else begin
                  for (p = 1; p <= pulses; p++) begin
                     push_segment(TONE_CONN, 60, (p == 1) ? MARK_DIGIT : MARK_NONE,
                                  (p == 1) ? d : 4'd0, ST_OK);
                     push_segment(TONE_IDLE, 40, MARK_NONE, 4'd0, ST_OK);
                  end
                  push_segment(TONE_IDLE, 400, MARK_NONE, 4'd0, ST_OK);
                  dialed_cnt = (dialed_cnt + 1) % 128;
               end
            end
            OP_END: begin
               if (phase != PH_DIAL) begin
                  push_error(ST_ORDER);
               end else begin
                  push_segment(TONE_SIL, 600, MARK_NEWLINE, 4'd0, ST_OK);
                  push_segment(TONE_FINISH, 0, MARK_NONE, 4'd0, ST_OK);
                  phase       = PH_IDLE;
                  station_cnt = 0;
                  dialed_cnt  = 0;
               end
            end
            default: begin
               if (phase != PH_IDLE) begin
                  push_error(ST_ORDER);
               end else begin
                  push_segment(TONE_SIL, 600, MARK_NONE, 4'd0, ST_OK);
                  for (p = 0; p < 15; p++) begin
                     push_segment(TONE_DISC, 25, MARK_NONE, 4'd0, ST_OK);
                     push_segment(TONE_IDLE, 25, MARK_NONE, 4'd0, ST_OK);
                  end
                  push_segment(TONE_SIL, 600, MARK_NONE, 4'd0, ST_OK);
                  push_segment(TONE_FINISH, 0, MARK_NONE, 4'd0, ST_OK);
               end
            end
         endcase
         // Every request yields at least one segment; flag the final one.
         seg      = pending_segments.pop_back();
         seg.last = 1'b1;
         pending_segments.push_back(seg);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $error("%s: expected %0d, actual %0d", name, want, got);
         end
      endfunction

      function void check_segment(logic [31:0] data, logic last);
         segment_type want;
         if (pending_segments.size() == 0) begin
            errors++;
            $error("segment 0x%08h arrived with no request waiting", data);
            return;
         end
         want = pending_segments.pop_front();
         compare_field("tone", 32'(want.tone), 32'(data[2:0]));
         compare_field("length_samples", 32'(want.length), 32'(data[21:3]));
         compare_field("marker", 32'(want.marker), 32'(data[24:22]));
         compare_field("marker_digit", 32'(want.mdig), 32'(data[28:25]));
         compare_field("status", 32'(want.status), 32'(data[30:29]));
         compare_field("pad", 32'd0, 32'(data[31]));
         compare_field("last", 32'(want.last), 32'(last));
      endfunction

      function int outstanding();
         return pending_segments.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              csr_we;
   logic [RATE_W-1:0] csr_wdata;

   bit                hold_go;
   bit                steady;
   segment_scoreboard board;

   imts_pulse_dial_sequencer #(
      .STATION_DIGITS  (STATION_LEN),
      .MAX_DIAL_DIGITS (DIAL_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            board.rate = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            board.predict_request(opcode_type'(req_tdata[1:0]), req_tdata[5:2]);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_segment(rsp_tdata, rsp_tlast);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("imts_pulse_dial_sequencer_tb: errors");
      $finish;
   end

   // Output side: random back-pressure, plus one long hold-off that lets the
   // sequencer fill up and stall its request input.
   initial begin : rsp_side
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 21);
      end
   end

   task automatic send_request(opcode_type op, logic [3:0] d);
      while (!steady && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {2'b00, d, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [RATE_W-1:0] rate_plan[6];
      int                phase_idx;
      int                sent;
      int                pick;
      int                n_dial;
      int                k;
      bit                force_long;

      board      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      hold_go    = 1'b0;
      steady     = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset sample rate: order errors, a bad digit,
      // a disconnect, a full station ID with digits zero and nine, the
      // dialed digit extremes and a clean call end.
      send_request(OP_DIGIT, 4'd5);
      send_request(OP_END, 4'd0);
      send_request(OP_DIGIT, 4'd12);
      send_request(OP_DISC, 4'd15);
      send_request(OP_START, 4'd0);
      send_request(OP_START, 4'd3);
      send_request(OP_DISC, 4'd0);
      send_request(OP_END, 4'd0);
      send_request(OP_DIGIT, 4'd15);
      send_request(OP_DIGIT, 4'd0);
      send_request(OP_DIGIT, 4'd9);
      send_request(OP_DIGIT, 4'd1);
      send_request(OP_DIGIT, 4'd2);
      send_request(OP_DIGIT, 4'd3);
      send_request(OP_DIGIT, 4'd4);
      send_request(OP_DIGIT, 4'd5);
      send_request(OP_DIGIT, 4'd10);
      send_request(OP_DIGIT, 4'd0);
      send_request(OP_DIGIT, 4'd9);
      send_request(OP_END, 4'd7);
      send_request(OP_END, 4'd0);
      settle();

      rate_plan[0] = 18'd8000;
      rate_plan[1] = 18'd192000;
      rate_plan[2] = 18'($urandom_range(8000, 192000));
      rate_plan[3] = 18'd262143;
      rate_plan[4] = 18'd0;
      rate_plan[5] = 18'd1;

      for (phase_idx = 0; phase_idx < 6; phase_idx++) begin
         csr_we    <= 1'b1;
         csr_wdata <= rate_plan[phase_idx];
         @(negedge clock);
         csr_we <= 1'b0;
         steady <= (phase_idx == 2);
         if (phase_idx == 1) begin
            hold_go <= 1'b1;
         end
         // Mostly complete calls with random digits; one phase opens with a
         // call that runs past the dialed digit limit.
         sent       = 0;
         force_long = (phase_idx == 3);
         while (sent < PHASE_REQUESTS) begin
            pick = $urandom_range(0, 99);
            if (force_long || pick < 70) begin
               if (force_long) begin
                  n_dial = $urandom_range(65, 67);
               end else if ($urandom_range(0, 99) < 2) begin
                  n_dial = $urandom_range(62, 66);
               end else begin
                  n_dial = $urandom_range(0, 8);
               end
               force_long = 1'b0;
               send_request(OP_START, 4'($urandom_range(0, 15)));
               for (k = 0; k < STATION_LEN + n_dial; k++) begin
                  send_request(OP_DIGIT, 4'($urandom_range(0, 9)));
               end
               if ($urandom_range(0, 99) < 92) begin
                  send_request(OP_END, 4'($urandom_range(0, 15)));
               end
               sent += STATION_LEN + n_dial + 2;
            end else if (pick < 80) begin
               send_request(OP_DISC, 4'($urandom_range(0, 15)));
               sent++;
            end else begin
               send_request(opcode_type'(2'($urandom_range(0, 3))),
                            4'($urandom_range(0, 15)));
               sent++;
            end
         end
         settle();
      end

      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("imts_pulse_dial_sequencer_tb: clean");
      end else begin
         $display("imts_pulse_dial_sequencer_tb: errors");
      end
      $finish;
   end

endmodule
